// ----- hw/rtl/rpst_pkg.sv -----
// Shared types and constants of the rendezvous pair session table.
package rpst_pkg;

    localparam int SESSION_ENTRIES = 16;
    localparam int IDX_W = (SESSION_ENTRIES > 1) ? $clog2(SESSION_ENTRIES) : 1;
    localparam int TIME_W = 40;

    localparam logic [1:0] KIND_WAITING = 2'd0;
    localparam logic [1:0] KIND_PAIRED  = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_TABLE_FULL   = 2'd1;
    localparam logic [1:0] ERR_SESSION_FULL = 2'd2;
    localparam logic [1:0] ERR_NO_FAMILY    = 2'd3;

    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_EXPIRE   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_UPDATE,
        ST_OUT,
        ST_EXPIRE
    } state_t;

    typedef struct packed {
        logic              family;
        logic [63:0]       addr_high;
        logic [63:0]       addr_low;
        logic [15:0]       port;
        logic [63:0]       ident;
        logic [TIME_W-1:0] rtime;
    } slot_t;

    typedef struct packed {
        logic              op;
        logic [63:0]       key;
        logic              family;
        logic [63:0]       addr_high;
        logic [63:0]       addr_low;
        logic [15:0]       port;
        logic [63:0]       ident;
        logic [TIME_W-1:0] now;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  err;
        logic [63:0] ident;
        logic        family;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] port;
    } res_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic pick;
        logic update;
        logic expire_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic last_idx;
        logic pick_fail;
        logic out_full;
    } stat_t;

endpackage

// ----- hw/rtl/rpst_ctrl.sv -----
// Sequencer of the session table: scan, pick, update, reply, expiry sweep.
module rpst_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  rpst_pkg::stat_t stat,
    output rpst_pkg::cmd_t  cmd
);
    import rpst_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = (stat.op == OP_EXPIRE) ? ST_EXPIRE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.last_idx) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:   state_next = stat.pick_fail ? ST_OUT : ST_UPDATE;
            ST_UPDATE: state_next = ST_OUT;
            ST_OUT: begin
                if (!stat.out_full) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXPIRE: begin
                if (stat.last_idx) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SCAN:   cmd.scan_step = 1'b1;
            ST_PICK:   cmd.pick = 1'b1;
            ST_UPDATE: cmd.update = 1'b1;
            ST_OUT:    cmd.out_load = !stat.out_full;
            ST_EXPIRE: cmd.expire_step = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule

// ----- hw/rtl/rpst_dp.sv -----
// Datapath: table storage, scan index, slot match, expiry test, result register.
module rpst_dp (
    input  logic            aclk,
    input  logic            aresetn,
    input  rpst_pkg::req_t  req_in,
    input  logic            cfg_we,
    input  logic [31:0]     cfg_data,
    input  rpst_pkg::cmd_t  cmd,
    output rpst_pkg::stat_t stat,
    output logic            out_valid,
    input  logic            out_ready,
    output rpst_pkg::res_t  out_res
);
    import rpst_pkg::*;

    logic [31:0]    expiry_reg;
    req_t           req_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic           match_found_reg, free_found_reg;
    logic [IDX_W-1:0] match_idx_reg, free_idx_reg, ent_reg;
    logic           new_reg;
    res_t           res_reg, out_reg;
    logic           out_valid_reg;

    logic             valid_reg [SESSION_ENTRIES];
    logic [63:0]      key_reg   [SESSION_ENTRIES];
    logic [1:0]       pres_reg  [SESSION_ENTRIES];
    slot_t            slot_reg  [SESSION_ENTRIES][2];

    // Scan view of the entry at the index
    logic        sc_valid, sc_hit, live0, live1;
    logic [1:0]  sc_pres;
    slot_t       sc_s0, sc_s1;

    function automatic logic is_live(input logic held, input slot_t sl,
                                     input logic [TIME_W-1:0] now,
                                     input logic [31:0] win);
        logic [TIME_W-1:0] age;
        age = now - sl.rtime;
        return held && ((now < sl.rtime) || (age < {{(TIME_W-32){1'b0}}, win}));
    endfunction

    function automatic logic same_src(input slot_t sl, input req_t r);
        return (sl.family == r.family) && (sl.addr_high == r.addr_high) &&
               (sl.addr_low == r.addr_low) && (sl.port == r.port);
    endfunction

    always_comb begin
        sc_valid = valid_reg[idx_reg];
        sc_pres  = pres_reg[idx_reg];
        sc_s0    = slot_reg[idx_reg][0];
        sc_s1    = slot_reg[idx_reg][1];
        sc_hit   = sc_valid && (key_reg[idx_reg] == req_reg.key);
        live0    = is_live(sc_pres[0], sc_s0, req_reg.now, expiry_reg);
        live1    = is_live(sc_pres[1], sc_s1, req_reg.now, expiry_reg);
    end

    // Update view of the chosen entry
    logic [1:0] up_pres, up_pres_new, up_onehot;
    slot_t      up_s0, up_s1, up_peer, up_wr;
    logic       up_ok, up_sel;
    res_t       up_res;
    res_t       full_res;

    always_comb begin
        full_res      = '0;
        full_res.kind = KIND_ERROR;
        full_res.err  = ERR_TABLE_FULL;
    end

    always_comb begin
        up_pres = new_reg ? 2'b00 : pres_reg[ent_reg];
        up_s0   = slot_reg[ent_reg][0];
        up_s1   = slot_reg[ent_reg][1];
        up_ok   = 1'b1;
        up_sel  = 1'b0;
        if (up_pres[0] && same_src(up_s0, req_reg)) begin
            up_sel = 1'b0;
        end else if (up_pres[1] && same_src(up_s1, req_reg)) begin
            up_sel = 1'b1;
        end else if (!up_pres[0]) begin
            up_sel = 1'b0;
        end else if (!up_pres[1]) begin
            up_sel = 1'b1;
        end else begin
            up_ok = 1'b0;
        end
        up_onehot   = up_sel ? 2'b10 : 2'b01;
        up_pres_new = up_pres | up_onehot;
        up_peer     = up_sel ? up_s0 : up_s1;
        up_wr.family    = req_reg.family;
        up_wr.addr_high = req_reg.addr_high;
        up_wr.addr_low  = req_reg.addr_low;
        up_wr.port      = req_reg.port;
        up_wr.ident     = req_reg.ident;
        up_wr.rtime     = req_reg.now;
        up_res = '0;
        if (!up_ok) begin
            up_res.kind = KIND_ERROR;
            up_res.err  = ERR_SESSION_FULL;
        end else if (up_pres_new != 2'b11) begin
            up_res.kind = KIND_WAITING;
        end else if (up_peer.family != req_reg.family) begin
            up_res.kind = KIND_ERROR;
            up_res.err  = ERR_NO_FAMILY;
        end else begin
            up_res.kind      = KIND_PAIRED;
            up_res.err       = ERR_NONE;
            up_res.ident     = up_peer.ident;
            up_res.family    = up_peer.family;
            up_res.addr_high = up_peer.addr_high;
            up_res.addr_low  = up_peer.addr_low;
            up_res.port      = up_peer.port;
        end
    end

    assign idx_next = cmd.load ? '0 : (idx_reg + 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expiry_reg      <= 32'd30000;
            idx_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < SESSION_ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
                pres_reg[i]  <= 2'b00;
            end
        end else begin
            if (cfg_we) begin
                expiry_reg <= cfg_data;
            end
            if (cmd.load) begin
                idx_reg         <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            if (cmd.scan_step || cmd.expire_step) begin
                idx_reg <= stat.last_idx ? '0 : idx_next;
            end
            if (cmd.scan_step) begin
                if (sc_hit && !match_found_reg) begin
                    match_found_reg <= 1'b1;
                end
                if (!sc_valid && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.expire_step && sc_valid && !live0 && !live1) begin
                valid_reg[idx_reg] <= 1'b0;
                pres_reg[idx_reg]  <= 2'b00;
            end
            if (cmd.update && up_ok) begin
                valid_reg[ent_reg] <= 1'b1;
                pres_reg[ent_reg]  <= up_pres_new;
            end
            // A load in the cycle the old result leaves keeps the flag up
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= req_in;
        end
        if (cmd.scan_step) begin
            if (sc_hit && !match_found_reg) begin
                match_idx_reg <= idx_reg;
            end
            if (!sc_valid && !free_found_reg) begin
                free_idx_reg <= idx_reg;
            end
        end
        if (cmd.pick) begin
            ent_reg <= match_found_reg ? match_idx_reg : free_idx_reg;
            new_reg <= !match_found_reg;
            res_reg <= full_res;
        end
        if (cmd.update) begin
            res_reg <= up_res;
            if (up_ok) begin
                slot_reg[ent_reg][up_sel] <= up_wr;
                if (new_reg) begin
                    key_reg[ent_reg] <= req_reg.key;
                end
            end
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    assign stat.op        = req_in.op;
    assign stat.last_idx  = (idx_reg == IDX_W'(SESSION_ENTRIES - 1));
    assign stat.pick_fail = !match_found_reg && !free_found_reg;
    assign stat.out_full  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

// ----- hw/rtl/rendezvous_pair_session_table.sv -----
// Rendezvous pair session table: top level, stream packing and wiring.
//
// Pairs two clients that register under a shared 64-bit session key. A
// register transaction (s_tuser = 0) walks all SESSION_ENTRIES entries one a
// cycle looking for the key and the first free entry, then claims or reuses
// an entry, matches the source to one of its two slots, stores the client
// and answers waiting, paired (with the peer's identity and address) or
// error. An expiry tick (s_tuser = 1) walks the table once, freeing entries
// with no slot refreshed inside the expiry window, and gives no result.
// A register transaction runs through the accepting cycle, a scan step
// per entry, then pick, slot update and result load. A table-full error
// skips the update; a tick runs through the accepting cycle and a sweep
// step per entry. One transaction is in work at a time. The result sits in
// an output register, so the next transaction is taken while it waits; a
// result that is ready while that register is still held stalls the block
// until the receiver takes the older one. The expiry window (ms) resets to
// 30000; the user must write it through cfg_* only while the block is idle,
// as the block itself does not enforce this.
module rendezvous_pair_session_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // session_key, src_family, src_addr_high, src_addr_low, src_port,
    // client_ident, now_ms, zero pad
    input  logic [319:0] s_tdata,
    // op
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // err_code, peer_ident, peer_family, peer_addr_high, peer_addr_low,
    // peer_port, zero pad
    output logic [215:0] m_tdata,
    // reply_kind
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);
    import rpst_pkg::*;

    req_t  req;
    res_t  res;
    cmd_t  cmd;
    stat_t stat;

    // Unpack the incoming transaction
    assign req.op        = s_tuser[0];
    assign req.key       = s_tdata[63:0];
    assign req.family    = s_tdata[64];
    assign req.addr_high = s_tdata[128:65];
    assign req.addr_low  = s_tdata[192:129];
    assign req.port      = s_tdata[208:193];
    assign req.ident     = s_tdata[272:209];
    assign req.now       = s_tdata[312:273];

    assign cfg_ready = 1'b1;

    rpst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rpst_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_in    (req),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Pack the result
    assign m_tuser = res.kind;
    assign m_tdata = {5'd0, res.port, res.addr_low, res.addr_high, res.family,
                      res.ident, res.err};

endmodule
